// ===== rtl/fcms_pkg.sv =====
// fcms_pkg: shared types, mode codes and register defaults for the
// flight control mode sequencer. No dependencies.

package fcms_pkg;

    // Field widths
    localparam int TIME_W = 32;
    localparam int ALT_W  = 14;
    localparam int ATT_W  = 12;
    localparam int DUR_W  = 16;
    localparam int PM_W   = 3;
    localparam int LM_W   = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Pitch mode codes
    localparam logic [PM_W-1:0] PM_GROUND   = 3'd0;
    localparam logic [PM_W-1:0] PM_ROTATION = 3'd1;
    localparam logic [PM_W-1:0] PM_FLIGHT   = 3'd2;
    localparam logic [PM_W-1:0] PM_FLARE_IN = 3'd3;
    localparam logic [PM_W-1:0] PM_FLARE    = 3'd4;
    localparam logic [PM_W-1:0] PM_TOUCH    = 3'd5;

    // Lateral mode codes
    localparam logic [LM_W-1:0] LM_GROUND   = 2'd0;
    localparam logic [LM_W-1:0] LM_ROTATION = 2'd1;
    localparam logic [LM_W-1:0] LM_FLIGHT   = 2'd2;
    localparam logic [LM_W-1:0] LM_TOUCH    = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ATT      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_P_ROT_TIME   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLARE_ALT    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLARE_TIME   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TD_ATT       = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_P_TD_TIME    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_L_ROT_TIME   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_L_TD_TIME    = 4'd7;

    // Register reset values
    localparam logic signed [ATT_W-1:0] ROT_ATT_RST    = 12'sd80;
    localparam logic [DUR_W-1:0]        P_ROT_TIME_RST = 16'd5000;
    localparam logic [ALT_W-1:0]        FLARE_ALT_RST  = 14'd50;
    localparam logic [DUR_W-1:0]        FLARE_TIME_RST = 16'd1000;
    localparam logic signed [ATT_W-1:0] TD_ATT_RST     = 12'sd40;
    localparam logic [DUR_W-1:0]        P_TD_TIME_RST  = 16'd5000;
    localparam logic [DUR_W-1:0]        L_ROT_TIME_RST = 16'd500;
    localparam logic [DUR_W-1:0]        L_TD_TIME_RST  = 16'd500;

    // Ground modes above this height are forced to flight
    localparam logic [ALT_W-1:0] FORCE_FLIGHT_ALT_FT = 14'd1000;

    typedef struct packed {
        logic signed [ATT_W-1:0] rotation_attitude_q4;
        logic [DUR_W-1:0]        pitch_rotation_time_ms;
        logic [ALT_W-1:0]        flare_entry_altitude_ft;
        logic [DUR_W-1:0]        flare_entry_time_ms;
        logic signed [ATT_W-1:0] touchdown_attitude_q4;
        logic [DUR_W-1:0]        pitch_touchdown_time_ms;
        logic [DUR_W-1:0]        lateral_rotation_time_ms;
        logic [DUR_W-1:0]        lateral_touchdown_time_ms;
    } cfg_t;

    typedef struct packed {
        logic [PM_W-1:0]   pitch_mode;
        logic [LM_W-1:0]   lateral_mode;
        logic [TIME_W-1:0] pitch_start;
        logic [TIME_W-1:0] lateral_start;
    } mode_state_t;

    typedef struct packed {
        logic [TIME_W-1:0]       time_ms;
        logic [ALT_W-1:0]        radio_altitude_ft;
        logic signed [ATT_W-1:0] pitch_attitude_q4;
        logic                    gear_compressed;
    } tick_t;

    // Timed phase done: modulo 2^32 elapsed time against a duration
    function automatic logic phase_done(
        input logic [TIME_W-1:0] now,
        input logic [TIME_W-1:0] start,
        input logic [DUR_W-1:0]  dur
    );
        logic [TIME_W-1:0] elapsed;
        elapsed = now - start;
        return elapsed >= {{(TIME_W-DUR_W){1'b0}}, dur};
    endfunction

endpackage

// ===== rtl/flight_control_mode_sequencer.sv =====
// Flight control mode sequencer top level. Depends on fcms_pkg, fcms_cfg_regs,
// fcms_mode_logic.
// A tick passes the input register, then the result register, and is offered on the
// mode channel from there. Throughput: one per cycle while the mode channel is not stalled, a single compare pass.
// Reset (rst_n, async, active low): both machines to ground, phase starts and
// configuration registers to their defaults, pipeline empty.

module flight_control_mode_sequencer
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [fcms_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fcms_pkg::CFG_DATA_W-1:0]      cfg_data,

    // tick input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [fcms_pkg::TIME_W-1:0]          time_ms,
    input  logic [fcms_pkg::ALT_W-1:0]           radio_altitude_ft,
    input  logic signed [fcms_pkg::ATT_W-1:0]    pitch_attitude_q4,
    input  logic                                 gear_compressed,

    // mode result channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [fcms_pkg::PM_W-1:0]            pitch_mode,
    output logic [fcms_pkg::LM_W-1:0]            lateral_mode
);

    fcms_pkg::cfg_t        cfg;
    fcms_pkg::tick_t       tick_reg;
    fcms_pkg::mode_state_t state_reg;
    fcms_pkg::mode_state_t state_next;

    logic                        s1_valid_reg;
    logic                        out_valid_reg;
    logic [fcms_pkg::PM_W-1:0]   pitch_mode_reg;
    logic [fcms_pkg::LM_W-1:0]   lateral_mode_reg;

    logic                        out_take;   // result register can load
    logic                        s1_fire;    // stage 1 transaction moves on
    logic                        in_fire;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    fcms_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // ------------------------------------------------------------------
    // Handshake. The result register frees up in the same cycle its
    // transaction leaves, so a full pipeline still streams one per cycle while out_stall is low.
    // ------------------------------------------------------------------
    assign out_take = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_take;
    assign in_stall = s1_valid_reg && !out_take;
    assign in_fire  = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            tick_reg.time_ms           <= time_ms;
            tick_reg.radio_altitude_ft <= radio_altitude_ft;
            tick_reg.pitch_attitude_q4 <= pitch_attitude_q4;
            tick_reg.gear_compressed   <= gear_compressed;
        end
    end

    // ------------------------------------------------------------------
    // Mode machines: state advances once per transaction leaving stage 1,
    // so the next tick in stage 1 already sees the updated modes.
    // ------------------------------------------------------------------
    fcms_mode_logic u_modes
    (
        .cfg  (cfg),
        .tick (tick_reg),
        .cur  (state_reg),
        .nxt  (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.pitch_mode    <= fcms_pkg::PM_GROUND;
            state_reg.lateral_mode  <= fcms_pkg::LM_GROUND;
            state_reg.pitch_start   <= '0;
            state_reg.lateral_start <= '0;
        end
        else if (s1_fire)
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_take)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            pitch_mode_reg   <= state_next.pitch_mode;
            lateral_mode_reg <= state_next.lateral_mode;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pitch_mode   = pitch_mode_reg;
    assign lateral_mode = lateral_mode_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // pitch machine never reaches the unused codes
    a_pitch_code: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pitch_mode <= fcms_pkg::PM_TOUCH)
        else $error("pitch mode left its legal range");

    // mode state only moves when a transaction leaves stage 1
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> $stable(state_reg))
        else $error("mode state changed without a transaction");

    // lateral rotation entry latches the tick timestamp
    a_lat_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && state_reg.lateral_mode == fcms_pkg::LM_GROUND &&
         state_next.lateral_mode == fcms_pkg::LM_ROTATION)
        |=> state_reg.lateral_start == $past(tick_reg.time_ms))
        else $error("lateral phase start not taken from tick");

    // a result delivered matches the state the transaction left behind
    a_result_match: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> (pitch_mode_reg == state_reg.pitch_mode &&
                     lateral_mode_reg == state_reg.lateral_mode && out_valid_reg))
        else $error("result register out of step with mode state");

endmodule

// ===== rtl/fcms_cfg_regs.sv =====
// fcms_cfg_regs: configuration register file, write-only port.
// Depends on fcms_pkg.

module fcms_cfg_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [fcms_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fcms_pkg::CFG_DATA_W-1:0]     cfg_data,
    output fcms_pkg::cfg_t                      cfg
);

    fcms_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rotation_attitude_q4      <= fcms_pkg::ROT_ATT_RST;
            cfg_reg.pitch_rotation_time_ms    <= fcms_pkg::P_ROT_TIME_RST;
            cfg_reg.flare_entry_altitude_ft   <= fcms_pkg::FLARE_ALT_RST;
            cfg_reg.flare_entry_time_ms       <= fcms_pkg::FLARE_TIME_RST;
            cfg_reg.touchdown_attitude_q4     <= fcms_pkg::TD_ATT_RST;
            cfg_reg.pitch_touchdown_time_ms   <= fcms_pkg::P_TD_TIME_RST;
            cfg_reg.lateral_rotation_time_ms  <= fcms_pkg::L_ROT_TIME_RST;
            cfg_reg.lateral_touchdown_time_ms <= fcms_pkg::L_TD_TIME_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                fcms_pkg::REG_ROT_ATT:
                    cfg_reg.rotation_attitude_q4 <= cfg_data[fcms_pkg::ATT_W-1:0];
                fcms_pkg::REG_P_ROT_TIME:
                    cfg_reg.pitch_rotation_time_ms <= cfg_data;
                fcms_pkg::REG_FLARE_ALT:
                    cfg_reg.flare_entry_altitude_ft <= cfg_data[fcms_pkg::ALT_W-1:0];
                fcms_pkg::REG_FLARE_TIME:
                    cfg_reg.flare_entry_time_ms <= cfg_data;
                fcms_pkg::REG_TD_ATT:
                    cfg_reg.touchdown_attitude_q4 <= cfg_data[fcms_pkg::ATT_W-1:0];
                fcms_pkg::REG_P_TD_TIME:
                    cfg_reg.pitch_touchdown_time_ms <= cfg_data;
                fcms_pkg::REG_L_ROT_TIME:
                    cfg_reg.lateral_rotation_time_ms <= cfg_data;
                fcms_pkg::REG_L_TD_TIME:
                    cfg_reg.lateral_touchdown_time_ms <= cfg_data;
                default:
                    ; // unknown index: dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/fcms_mode_logic.sv =====
// fcms_mode_logic: next-state logic of the pitch and lateral mode machines
// for one tick. Purely combinational. Depends on fcms_pkg.

module fcms_mode_logic
(
    input  fcms_pkg::cfg_t        cfg,
    input  fcms_pkg::tick_t       tick,
    input  fcms_pkg::mode_state_t cur,
    output fcms_pkg::mode_state_t nxt
);

    logic                          high;
    logic                          att_rot;
    logic [fcms_pkg::PM_W-1:0]     pm_forced;
    logic [fcms_pkg::PM_W-1:0]     pitch_mode_next;
    logic [fcms_pkg::TIME_W-1:0]   pitch_start_next;
    logic [fcms_pkg::LM_W-1:0]     lateral_mode_next;
    logic [fcms_pkg::TIME_W-1:0]   lateral_start_next;

    assign high    = tick.radio_altitude_ft > fcms_pkg::FORCE_FLIGHT_ALT_FT;
    assign att_rot = tick.pitch_attitude_q4 > cfg.rotation_attitude_q4;

    // Lateral: transitions first, forcing only as the last resort
    always_comb
    begin
        lateral_mode_next  = cur.lateral_mode;
        lateral_start_next = cur.lateral_start;
        priority if (cur.lateral_mode == fcms_pkg::LM_GROUND && att_rot)
        begin
            lateral_mode_next  = fcms_pkg::LM_ROTATION;
            lateral_start_next = tick.time_ms;
        end
        else if (cur.lateral_mode == fcms_pkg::LM_ROTATION &&
                 fcms_pkg::phase_done(tick.time_ms, cur.lateral_start,
                                      cfg.lateral_rotation_time_ms))
        begin
            lateral_mode_next = fcms_pkg::LM_FLIGHT;
        end
        else if (cur.lateral_mode == fcms_pkg::LM_FLIGHT && tick.gear_compressed)
        begin
            lateral_mode_next  = fcms_pkg::LM_TOUCH;
            lateral_start_next = tick.time_ms;
        end
        else if (cur.lateral_mode == fcms_pkg::LM_TOUCH &&
                 fcms_pkg::phase_done(tick.time_ms, cur.lateral_start,
                                      cfg.lateral_touchdown_time_ms))
        begin
            lateral_mode_next = fcms_pkg::LM_GROUND;
        end
        else if (cur.lateral_mode == fcms_pkg::LM_GROUND && high)
        begin
            lateral_mode_next = fcms_pkg::LM_FLIGHT;
        end
        else
        begin
            // nothing applies: hold
        end
    end

    // Pitch: forcing first, then one transition from the forced mode
    assign pm_forced = (cur.pitch_mode == fcms_pkg::PM_GROUND && high) ?
                       fcms_pkg::PM_FLIGHT : cur.pitch_mode;

    always_comb
    begin
        pitch_mode_next  = pm_forced;
        pitch_start_next = cur.pitch_start;
        unique case (pm_forced)
            fcms_pkg::PM_GROUND:
                if (att_rot)
                begin
                    pitch_mode_next  = fcms_pkg::PM_ROTATION;
                    pitch_start_next = tick.time_ms;
                end
            fcms_pkg::PM_ROTATION:
                if (fcms_pkg::phase_done(tick.time_ms, cur.pitch_start,
                                         cfg.pitch_rotation_time_ms))
                    pitch_mode_next = fcms_pkg::PM_FLIGHT;
            fcms_pkg::PM_FLIGHT:
                if (tick.radio_altitude_ft <= cfg.flare_entry_altitude_ft)
                begin
                    pitch_mode_next  = fcms_pkg::PM_FLARE_IN;
                    pitch_start_next = tick.time_ms;
                end
            fcms_pkg::PM_FLARE_IN:
                if (fcms_pkg::phase_done(tick.time_ms, cur.pitch_start,
                                         cfg.flare_entry_time_ms))
                    pitch_mode_next = fcms_pkg::PM_FLARE;
            fcms_pkg::PM_FLARE:
                if (tick.gear_compressed &&
                    tick.pitch_attitude_q4 < cfg.touchdown_attitude_q4)
                begin
                    pitch_mode_next  = fcms_pkg::PM_TOUCH;
                    pitch_start_next = tick.time_ms;
                end
            fcms_pkg::PM_TOUCH:
                if (fcms_pkg::phase_done(tick.time_ms, cur.pitch_start,
                                         cfg.pitch_touchdown_time_ms))
                    pitch_mode_next = fcms_pkg::PM_GROUND;
            default:
                ; // unused codes hold
        endcase
    end

    assign nxt = {pitch_mode_next, lateral_mode_next, pitch_start_next, lateral_start_next};

endmodule

// ===== verif/fcms_checker.sv =====
`timescale 1ns / 1ps
// fcms_checker: watches the tick and mode channels of the flight control mode
// sequencer, predicts every mode transaction and compares. Uses fcms_pkg.

module fcms_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [fcms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fcms_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic [fcms_pkg::TIME_W-1:0]        time_ms,
    input  logic [fcms_pkg::ALT_W-1:0]         radio_altitude_ft,
    input  logic signed [fcms_pkg::ATT_W-1:0]  pitch_attitude_q4,
    input  logic                               gear_compressed,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [fcms_pkg::PM_W-1:0]          pitch_mode,
    input  logic [fcms_pkg::LM_W-1:0]          lateral_mode,
    output int                                 mismatch_count,
    output int                                 modes_owed
);

    typedef struct packed {
        logic [fcms_pkg::PM_W-1:0] pitch;
        logic [fcms_pkg::LM_W-1:0] lateral;
    } mode_pair_t;

    // register copies
    logic signed [fcms_pkg::ATT_W-1:0] rot_att;
    logic signed [fcms_pkg::ATT_W-1:0] td_att;
    logic [fcms_pkg::ALT_W-1:0]        flare_alt;
    logic [fcms_pkg::DUR_W-1:0]        p_rot_ms;
    logic [fcms_pkg::DUR_W-1:0]        flare_ms;
    logic [fcms_pkg::DUR_W-1:0]        p_td_ms;
    logic [fcms_pkg::DUR_W-1:0]        l_rot_ms;
    logic [fcms_pkg::DUR_W-1:0]        l_td_ms;

    // machine state
    logic [fcms_pkg::PM_W-1:0]   pitch_now;
    logic [fcms_pkg::LM_W-1:0]   lateral_now;
    logic [fcms_pkg::TIME_W-1:0] pitch_since;
    logic [fcms_pkg::TIME_W-1:0] lateral_since;

    mode_pair_t modes_due[$];
    int         faults;

    function automatic logic timer_expired(
        input logic [fcms_pkg::TIME_W-1:0] now,
        input logic [fcms_pkg::TIME_W-1:0] since,
        input logic [fcms_pkg::DUR_W-1:0]  dur
    );
        logic [fcms_pkg::TIME_W-1:0] span;
        span = now - since;
        return span >= fcms_pkg::TIME_W'(dur);
    endfunction

    function automatic mode_pair_t advance_modes(
        input logic [fcms_pkg::TIME_W-1:0]       now,
        input logic [fcms_pkg::ALT_W-1:0]        alt,
        input logic signed [fcms_pkg::ATT_W-1:0] att,
        input logic                              gear
    );
        logic       above;
        mode_pair_t r;
        above = alt > fcms_pkg::FORCE_FLIGHT_ALT_FT;

        // lateral forces flight only when nothing else fires
        if (lateral_now == fcms_pkg::LM_GROUND && att > rot_att)
        begin
            lateral_since = now;
            lateral_now   = fcms_pkg::LM_ROTATION;
        end
        else if (lateral_now == fcms_pkg::LM_ROTATION &&
                 timer_expired(now, lateral_since, l_rot_ms))
            lateral_now = fcms_pkg::LM_FLIGHT;
        else if (lateral_now == fcms_pkg::LM_FLIGHT && gear)
        begin
            lateral_since = now;
            lateral_now   = fcms_pkg::LM_TOUCH;
        end
        else if (lateral_now == fcms_pkg::LM_TOUCH &&
                 timer_expired(now, lateral_since, l_td_ms))
            lateral_now = fcms_pkg::LM_GROUND;
        else if (lateral_now == fcms_pkg::LM_GROUND && above)
            lateral_now = fcms_pkg::LM_FLIGHT;

        // pitch forces first, then one transition may follow
        if (pitch_now == fcms_pkg::PM_GROUND && above)
            pitch_now = fcms_pkg::PM_FLIGHT;
        case (pitch_now)
            fcms_pkg::PM_GROUND:
                if (att > rot_att)
                begin
                    pitch_since = now;
                    pitch_now   = fcms_pkg::PM_ROTATION;
                end
            fcms_pkg::PM_ROTATION:
                if (timer_expired(now, pitch_since, p_rot_ms))
                    pitch_now = fcms_pkg::PM_FLIGHT;
            fcms_pkg::PM_FLIGHT:
                if (alt <= flare_alt)
                begin
                    pitch_since = now;
                    pitch_now   = fcms_pkg::PM_FLARE_IN;
                end
            fcms_pkg::PM_FLARE_IN:
                if (timer_expired(now, pitch_since, flare_ms))
                    pitch_now = fcms_pkg::PM_FLARE;
            fcms_pkg::PM_FLARE:
                if (gear && att < td_att)
                begin
                    pitch_since = now;
                    pitch_now   = fcms_pkg::PM_TOUCH;
                end
            fcms_pkg::PM_TOUCH:
                if (timer_expired(now, pitch_since, p_td_ms))
                    pitch_now = fcms_pkg::PM_GROUND;
            default:
                ;
        endcase

        r.pitch   = pitch_now;
        r.lateral = lateral_now;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mode_pair_t want;
        if (!rst_n)
        begin
            rot_att        <= fcms_pkg::ROT_ATT_RST;
            p_rot_ms       <= fcms_pkg::P_ROT_TIME_RST;
            flare_alt      <= fcms_pkg::FLARE_ALT_RST;
            flare_ms       <= fcms_pkg::FLARE_TIME_RST;
            td_att         <= fcms_pkg::TD_ATT_RST;
            p_td_ms        <= fcms_pkg::P_TD_TIME_RST;
            l_rot_ms       <= fcms_pkg::L_ROT_TIME_RST;
            l_td_ms        <= fcms_pkg::L_TD_TIME_RST;
            pitch_now      = fcms_pkg::PM_GROUND;
            lateral_now    = fcms_pkg::LM_GROUND;
            pitch_since    = '0;
            lateral_since  = '0;
            faults         = 0;
            modes_due.delete();
            mismatch_count <= 0;
            modes_owed     <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    fcms_pkg::REG_ROT_ATT:    rot_att   <= cfg_data[fcms_pkg::ATT_W-1:0];
                    fcms_pkg::REG_P_ROT_TIME: p_rot_ms  <= cfg_data[fcms_pkg::DUR_W-1:0];
                    fcms_pkg::REG_FLARE_ALT:  flare_alt <= cfg_data[fcms_pkg::ALT_W-1:0];
                    fcms_pkg::REG_FLARE_TIME: flare_ms  <= cfg_data[fcms_pkg::DUR_W-1:0];
                    fcms_pkg::REG_TD_ATT:     td_att    <= cfg_data[fcms_pkg::ATT_W-1:0];
                    fcms_pkg::REG_P_TD_TIME:  p_td_ms   <= cfg_data[fcms_pkg::DUR_W-1:0];
                    fcms_pkg::REG_L_ROT_TIME: l_rot_ms  <= cfg_data[fcms_pkg::DUR_W-1:0];
                    fcms_pkg::REG_L_TD_TIME:  l_td_ms   <= cfg_data[fcms_pkg::DUR_W-1:0];
                    default:                  ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (modes_due.size() == 0)
                begin
                    if (faults < 10)
                        $display("%0t: unexpected mode transaction: pitch %0d lateral %0d",
                                 $time, pitch_mode, lateral_mode);
                    faults++;
                end
                else
                begin
                    want = modes_due.pop_front();
                    if (want.pitch !== pitch_mode || want.lateral !== lateral_mode)
                    begin
                        if (faults < 10)
                            $display({"%0t: mode mismatch: expected pitch %0d lateral %0d,",
                                      " got pitch %0d lateral %0d"}, $time,
                                     want.pitch, want.lateral, pitch_mode, lateral_mode);
                        faults++;
                    end
                end
            end

            if (in_valid && !in_stall)
                modes_due.push_back(advance_modes(time_ms, radio_altitude_ft,
                                                  pitch_attitude_q4, gear_compressed));

            mismatch_count <= faults;
            modes_owed     <= modes_due.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// testbench: drives update ticks and register writes into the flight control
// mode sequencer and gives the verdict. Uses fcms_pkg and fcms_checker.

module testbench;

    localparam int WATCHDOG_LIMIT  = 4000;  // cycles with no transaction at all
    localparam int ITEMS_PER_PHASE = 140;
    localparam int SETTLE_CYCLES   = 4;     // result latency plus margin
    localparam int ATT_MAX         = (1 << (fcms_pkg::ATT_W - 1)) - 1;
    localparam int ATT_MIN         = -(1 << (fcms_pkg::ATT_W - 1));
    localparam int ALT_MAX         = (1 << fcms_pkg::ALT_W) - 1;
    localparam int DUR_MAX         = (1 << fcms_pkg::DUR_W) - 1;

    // Profile stages the random stimulus walks through, one full flight per lap
    typedef enum int { TAXI, TAKEOFF, CLIMB, CRUISE, APPROACH, FLARE_OUT, ROLLOUT } stage_e;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_wr_en;
    logic [fcms_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [fcms_pkg::CFG_DATA_W-1:0]     cfg_data;
    logic                                in_valid;
    logic                                in_stall;
    logic [fcms_pkg::TIME_W-1:0]         time_ms;
    logic [fcms_pkg::ALT_W-1:0]          radio_altitude_ft;
    logic signed [fcms_pkg::ATT_W-1:0]   pitch_attitude_q4;
    logic                                gear_compressed;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic [fcms_pkg::PM_W-1:0]           pitch_mode;
    logic [fcms_pkg::LM_W-1:0]           lateral_mode;

    int mismatch_count;
    int modes_owed;
    int quiet_cycles  = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // Stimulus shaping: a copy of the thresholds so the profile lands near them
    int                          plan_rot_att   = 80;
    int                          plan_td_att    = 40;
    int                          plan_flare_alt = 50;
    int unsigned                 step_max       = 2501;
    logic [fcms_pkg::TIME_W-1:0] now_ms;
    stage_e                      stage = TAXI;

    flight_control_mode_sequencer i_dut (.*);

    fcms_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver side: random stall at the rate of the current phase
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Watchdog: any accepted transaction on either channel restarts the count
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic int pick(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic logic signed [fcms_pkg::ATT_W-1:0] att_clip(input int a);
        if (a > ATT_MAX)
            return fcms_pkg::ATT_W'(ATT_MAX);
        if (a < ATT_MIN)
            return fcms_pkg::ATT_W'(ATT_MIN);
        return fcms_pkg::ATT_W'(a);
    endfunction

    function automatic logic [fcms_pkg::ALT_W-1:0] alt_clip(input int a);
        if (a < 0)
            return '0;
        if (a > ALT_MAX)
            return fcms_pkg::ALT_W'(ALT_MAX);
        return fcms_pkg::ALT_W'(a);
    endfunction

    // Mostly steps around the configured durations; now and then a huge jump,
    // which in modulo arithmetic is as good as the clock running backwards
    function automatic logic [fcms_pkg::TIME_W-1:0] time_step();
        int pct;
        pct = pick(0, 99);
        if (pct < 10)
            return '0;
        else if (pct < 80)
            return fcms_pkg::TIME_W'($urandom_range(1, step_max));
        else if (pct < 95)
            return fcms_pkg::TIME_W'($urandom_range(step_max, 3 * step_max));
        return fcms_pkg::TIME_W'($urandom());
    endfunction

    // Register data carries noise in the bits above a field's width
    function automatic logic [fcms_pkg::CFG_DATA_W-1:0] with_spare_noise(
        input int value, input int width);
        logic [fcms_pkg::CFG_DATA_W-1:0] d;
        int                              b;
        d = fcms_pkg::CFG_DATA_W'($urandom());
        for (b = 0; b < width; b++)
            d[b] = value[b];
        return d;
    endfunction

    // One tick transaction; the sender may idle first but never drops a payload
    task automatic send_tick(
        input logic [fcms_pkg::TIME_W-1:0]       t,
        input logic [fcms_pkg::ALT_W-1:0]        alt,
        input logic signed [fcms_pkg::ATT_W-1:0] att,
        input logic                              gear
    );
        while (pick(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid          <= 1'b1;
        time_ms           <= t;
        radio_altitude_ft <= alt;
        pitch_attitude_q4 <= att;
        gear_compressed   <= gear;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stop sending and let every outstanding mode transaction drain out
    task automatic wait_for_modes();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (modes_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [fcms_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fcms_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Writes all eight registers plus one index past the end, which must be ignored
    task automatic configure(
        input int rot_att, input int p_rot, input int flare_alt, input int flare_time,
        input int td_att, input int p_td, input int l_rot, input int l_td
    );
        int largest;
        write_reg(fcms_pkg::REG_ROT_ATT,    with_spare_noise(rot_att, fcms_pkg::ATT_W));
        write_reg(fcms_pkg::REG_P_ROT_TIME, fcms_pkg::CFG_DATA_W'(p_rot));
        write_reg(fcms_pkg::REG_FLARE_ALT,  with_spare_noise(flare_alt, fcms_pkg::ALT_W));
        write_reg(fcms_pkg::REG_FLARE_TIME, fcms_pkg::CFG_DATA_W'(flare_time));
        write_reg(fcms_pkg::REG_TD_ATT,     with_spare_noise(td_att, fcms_pkg::ATT_W));
        write_reg(fcms_pkg::REG_P_TD_TIME,  fcms_pkg::CFG_DATA_W'(p_td));
        write_reg(fcms_pkg::REG_L_ROT_TIME, fcms_pkg::CFG_DATA_W'(l_rot));
        write_reg(fcms_pkg::REG_L_TD_TIME,  fcms_pkg::CFG_DATA_W'(l_td));
        write_reg(fcms_pkg::CFG_IDX_W'(fcms_pkg::REG_L_TD_TIME + pick(1, 8)),
                  fcms_pkg::CFG_DATA_W'($urandom()));
        cfg_wr_en <= 1'b0;

        plan_rot_att   = int'(att_clip(rot_att));
        plan_td_att    = int'(att_clip(td_att));
        plan_flare_alt = flare_alt;
        largest = p_rot;
        if (flare_time > largest) largest = flare_time;
        if (p_td > largest)       largest = p_td;
        if (l_rot > largest)      largest = l_rot;
        if (l_td > largest)       largest = l_td;
        step_max = largest / 2 + 1;
    endtask

    // One random tick: mostly a plausible flight profile with random content,
    // the rest noise in altitude, attitude and gear, with a random or the current time
    task automatic fly_tick();
        int   alt;
        int   att;
        logic gear;
        now_ms = now_ms + time_step();
        if (pick(0, 99) < 15)
        begin
            send_tick(pick(0, 1) ? fcms_pkg::TIME_W'($urandom()) : now_ms,
                      fcms_pkg::ALT_W'($urandom()),
                      fcms_pkg::ATT_W'($urandom()), 1'($urandom()));
        end
        else
        begin
            gear = 1'b0;
            case (stage)
                TAXI:
                begin
                    alt  = pick(0, 20);
                    att  = plan_rot_att - pick(0, 100);
                    gear = 1'b1;
                end
                TAKEOFF:
                begin
                    alt  = pick(0, 40);
                    att  = plan_rot_att + (pick(0, 7) == 0 ? 0 : pick(1, 100));
                    gear = 1'($urandom());
                end
                CLIMB:
                begin
                    alt = pick(40, 3000);
                    att = plan_rot_att + pick(-100, 100);
                end
                CRUISE:
                begin
                    // hug the forcing height now and then
                    alt  = (pick(0, 3) == 0) ?
                           int'(fcms_pkg::FORCE_FLIGHT_ALT_FT) + pick(-1, 2) :
                           pick(900, ALT_MAX);
                    att  = pick(-300, 300);
                    gear = (pick(0, 9) == 0);
                end
                APPROACH:
                begin
                    alt = plan_flare_alt + pick(-100, 50);
                    att = pick(-200, 200);
                end
                FLARE_OUT:
                begin
                    alt  = pick(0, plan_flare_alt);
                    att  = plan_td_att + pick(-50, 50);
                    gear = 1'($urandom());
                end
                default:
                begin
                    // rollout: gear down, nose at or below the touchdown attitude
                    alt  = pick(0, 10);
                    att  = plan_td_att - (pick(0, 7) == 0 ? 0 : pick(1, 100));
                    gear = 1'b1;
                end
            endcase
            send_tick(now_ms, alt_clip(alt), att_clip(att), gear);
            if (pick(0, 3) == 0)
                stage = stage.next();
        end
    endtask

    initial
    begin
        int phase;
        int k;
        int phase_send;
        int phase_stall;

        rst_n             <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_index         <= fcms_pkg::REG_ROT_ATT;
        cfg_data          <= '0;
        in_valid          <= 1'b0;
        time_ms           <= '0;
        radio_altitude_ft <= '0;
        pitch_attitude_q4 <= '0;
        gear_compressed   <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk with reset thresholds: attitude on the rotation
        // threshold, altitude on the forcing height, lateral rotating above
        // 1000 ft while pitch is forced, timers one short and exactly on time,
        // touchdown attitude boundary, clock going backwards, wrap across zero
        send_tick(0,              0,     80,    1'b1);
        send_tick(10,             1000,  0,     1'b1);
        send_tick(20,             1001,  2047,  1'b0);
        send_tick(519,            16383, -2048, 1'b0);
        send_tick(520,            16383, -2048, 1'b0);
        send_tick(600,            50,    0,     1'b0);
        send_tick(1599,           0,     0,     1'b0);
        send_tick(1600,           0,     0,     1'b0);
        send_tick(1700,           0,     40,    1'b1);
        send_tick(1800,           0,     39,    1'b1);
        send_tick(2200,           0,     -1440, 1'b1);
        send_tick(1000,           0,     0,     1'b1);
        send_tick(32'hFFFF_FE00,  0,     1440,  1'b1);
        send_tick(32'h0000_00F3,  0,     0,     1'b1);
        send_tick(4488,           2000,  0,     1'b1);
        send_tick(4488,           2000,  0,     1'b0);
        send_tick(32'hFFFF_FFFF,  51,    0,     1'b0);
        wait_for_modes();

        // Full-width thresholds and zero durations but a maximal lateral touchdown time: a
        // forced pitch machine can drop straight into flare entry, zero timers end on the following tick
        configure(ATT_MIN, 0, ALT_MAX, 0, ATT_MAX, 0, 0, DUR_MAX);
        send_tick(5000, 0,     -2048, 1'b0);
        send_tick(5000, 1001,  -2047, 1'b0);
        send_tick(5001, 16383, 0,     1'b1);
        send_tick(5002, 0,     2047,  1'b1);
        send_tick(5003, 0,     0,     1'b1);
        send_tick(5003, 1200,  -2048, 1'b0);
        now_ms = 32'd6000;

        for (phase = 0; phase < 5; phase++)
        begin
            wait_for_modes();
            case (phase)
                0:
                begin
                    configure(64, 300, 50, 200, 40, 300, 100, 150);
                    phase_send  = 0;
                    phase_stall = 0;
                end
                1:
                begin
                    configure(1440, DUR_MAX, 0, DUR_MAX, -1440, DUR_MAX, DUR_MAX, DUR_MAX);
                    phase_send  = 65;
                    phase_stall = 0;
                end
                2:
                begin
                    configure(-1440, 0, ALT_MAX, 0, 1440, 0, 0, 0);
                    phase_send  = 0;
                    phase_stall = 65;
                end
                3:
                begin
                    configure(pick(-1440, 1440), pick(0, 3000), pick(0, 1500), pick(0, 3000),
                              pick(-1440, 1440), pick(0, 3000), pick(0, 3000), pick(0, 3000));
                    phase_send  = 33;
                    phase_stall = 33;
                end
                default:
                begin
                    configure(int'(fcms_pkg::ROT_ATT_RST), fcms_pkg::P_ROT_TIME_RST,
                              fcms_pkg::FLARE_ALT_RST, fcms_pkg::FLARE_TIME_RST,
                              int'(fcms_pkg::TD_ATT_RST), fcms_pkg::P_TD_TIME_RST,
                              fcms_pkg::L_ROT_TIME_RST, fcms_pkg::L_TD_TIME_RST);
                    phase_send  = 0;
                    phase_stall = 0;
                end
            endcase

            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // a clean burst at the start of every fifty transactions
                send_idle_pct = (k % 50 < 10) ? 0 : phase_send;
                stall_pct     = (k % 50 < 10) ? 0 : phase_stall;
                // mid-phase hold-off until the block has caught up
                if (k == ITEMS_PER_PHASE / 2)
                    wait_for_modes();
                fly_tick();
            end
        end

        wait_for_modes();
        if (mismatch_count == 0 && modes_owed == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// ===== flight_control_mode_sequencer.f =====
rtl/fcms_pkg.sv
rtl/fcms_cfg_regs.sv
rtl/fcms_mode_logic.sv
rtl/flight_control_mode_sequencer.sv
verif/fcms_checker.sv
verif/testbench.sv
